// ===== hw/rtl/uctc_pkg.sv =====
`timescale 1ns / 1ps

package uctc_pkg;

    // Cycles from an accepted command to its result strobe.
    localparam int PIPE_DEPTH    = 10;
    // Stages that the civil to Unix path needs before its delay line.
    localparam int TO_UNIX_DEPTH = 4;
    localparam int OFS_W         = 5;

    localparam logic [16:0] SEC_PER_DAY  = 17'd86400;
    localparam logic [11:0] SEC_PER_HOUR = 12'd3600;
    localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
    localparam logic [12:0] YEAR_BIAS    = 13'd400;
    // One era of days plus the day count from 0000-03-01 to 1970-01-01.
    localparam logic [21:0] CIVIL_DAY_BIAS = 22'd865565;

    // Reciprocals for division by constants: floor(x * R >> k).
    localparam logic [26:0] RECIP_675_36 = 27'd101806633;
    localparam logic [12:0] RECIP_25_17  = 13'd5243;
    localparam logic [15:0] RECIP_365_24 = 16'd45965;
    localparam logic [17:0] RECIP_365_26 = 18'd183861;
    localparam logic [17:0] RECIP_60_23  = 18'd139811;
    localparam logic [11:0] RECIP_60_17  = 12'd2185;
    localparam logic [9:0]  RECIP_100_16 = 10'd656;
    localparam logic [11:0] RECIP_153_19 = 12'd3427;

    // Day numbers seen by the Unix to civil path fall in era 4 or era 5.
    localparam logic [15:0] ERA5_FIRST_DAY = 16'd11018;
    localparam logic [17:0] DOE_BIAS       = 18'd135079;
    localparam logic [17:0] DAYS_PER_ERA   = 18'd146097;
    localparam logic [17:0] DOE_CENT1      = 18'd36524;
    localparam logic [17:0] DOE_CENT2      = 18'd73048;
    localparam logic [17:0] DOE_CENT3      = 18'd109572;
    localparam logic [17:0] DOE_LAST       = 18'd146096;
    localparam logic [11:0] ERA4_YEAR      = 12'd1600;
    localparam logic [11:0] ERA5_YEAR      = 12'd2000;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } civil_t;

    // First day of a March-based month index within the year: (153 * mp + 2) / 5.
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] r;
        case (mp)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            4'd12:   r = 9'd367;
            4'd13:   r = 9'd398;
            4'd14:   r = 9'd428;
            4'd15:   r = 9'd459;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/uctc_to_unix.sv =====
`timescale 1ns / 1ps

module uctc_to_unix import uctc_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [OFS_W-1:0]  zone_offset,
    input  civil_t            civil_in,
    output logic              out_valid,
    output logic [31:0]       unix_seconds
);

    localparam int PAD = PIPE_DEPTH - TO_UNIX_DEPTH;

    logic [PIPE_DEPTH-1:0] valid_reg;

    // Stage 1: shifted year, day of year, local time of day less the offset.
    logic        le2;
    logic [3:0]  mpc;
    logic [6:0]  hour_diff;
    logic [12:0] ylp_next, ylp_reg;
    logic [9:0]  doy_next, doy1_reg, doy2_reg;
    logic [18:0] tod_next, tod1_reg, tod2_reg, tod3_reg;

    // Stage 2: year day counts.
    logic [23:0] p100;
    logic [20:0] y365_next, y365_reg;
    logic [10:0] y4_reg;
    logic [5:0]  q100_next, q100_reg;

    // Stage 3: day number relative to the epoch.
    logic [21:0] days_next, days_reg;

    // Stage 4: seconds.
    logic [31:0] days_ext;
    logic [48:0] day_prod;
    logic [31:0] secs_next, secs_reg;
    logic [31:0] pad_reg [PAD];

    always_comb
    begin
        le2       = (civil_in.month <= 4'd2);
        mpc       = le2 ? civil_in.month + 4'd9 : civil_in.month - 4'd3;
        ylp_next  = 13'(civil_in.year) + YEAR_BIAS - 13'(le2);
        doy_next  = 10'(month_start(mpc)) + 10'(civil_in.day) - 10'd1;
        hour_diff = 7'(civil_in.hour) - {{2{zone_offset[OFS_W-1]}}, zone_offset};
        tod_next  = {{12{hour_diff[6]}}, hour_diff} * 19'(SEC_PER_HOUR)
                  + 19'(civil_in.minute) * 19'd60 + 19'(civil_in.second);

        y365_next = 21'(ylp_reg) * 21'(DAYS_PER_YEAR);
        p100      = 24'(ylp_reg[12:2]) * 24'(RECIP_25_17);
        q100_next = p100[22:17];

        days_next = 22'(y365_reg) + 22'(y4_reg) - 22'(q100_reg) + 22'(q100_reg[5:2])
                  + {{12{doy2_reg[9]}}, doy2_reg} - CIVIL_DAY_BIAS;

        days_ext  = {{10{days_reg[21]}}, days_reg};
        day_prod  = 49'(days_ext) * 49'(SEC_PER_DAY);
        secs_next = day_prod[31:0] + {{13{tod3_reg[18]}}, tod3_reg};
    end

    always_ff @(posedge clk)
    begin
        ylp_reg  <= ylp_next;
        doy1_reg <= doy_next;
        tod1_reg <= tod_next;

        y365_reg <= y365_next;
        y4_reg   <= ylp_reg[12:2];
        q100_reg <= q100_next;
        doy2_reg <= doy1_reg;
        tod2_reg <= tod1_reg;

        days_reg <= days_next;
        tod3_reg <= tod2_reg;

        secs_reg <= secs_next;

        // Delay line that matches the civil path's latency.
        pad_reg[0] <= secs_reg;
        for (int i = 1; i < PAD; i++)
        begin
            pad_reg[i] <= pad_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[PIPE_DEPTH-2:0], in_valid};
        end
    end

    assign out_valid    = valid_reg[PIPE_DEPTH-1];
    assign unix_seconds = pad_reg[PAD-1];

endmodule

// ===== hw/rtl/uctc_to_civil.sv =====
`timescale 1ns / 1ps

module uctc_to_civil import uctc_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [OFS_W-1:0]  zone_offset,
    input  logic [31:0]       unix_seconds,
    output logic              out_valid,
    output civil_t            civil_out
);

    logic [PIPE_DEPTH-1:0] valid_reg;

    // Stage 1: local seconds plus one day, so the count is never negative.
    logic [32:0] ofs_ext;
    logic [32:0] t_next, t_reg;

    // Stage 2: day count.
    logic [52:0] pday;
    logic [15:0] q_next, q_reg;
    logic [16:0] tlo_reg;

    // Stage 3: second of day, day of era.
    logic [32:0] qd;
    logic        era5_next;
    logic [16:0] rem_next, rem3_reg, rem4_reg;
    logic [17:0] doe_next, doe3_reg, doe4_reg, doe5_reg, doe6_reg, doe7_reg;
    logic        era3_reg, era4_reg, era5_reg, era6_reg, era7_reg, era8_reg, era9_reg;

    // Stage 4: leap corrections and minute of day.
    logic [31:0] pa;
    logic [34:0] p60;
    logic [6:0]  a_next, a_reg;
    logic [2:0]  b_next, b_reg;
    logic        c_next, c_reg;
    logic [10:0] q60_next, q60_4_reg, q60_5_reg;

    // Stage 5: corrected day of era, second and hour.
    logic [17:0] adj_next, adj_reg;
    logic [16:0] s60, sec_full;
    logic [22:0] ph;
    logic [5:0]  sec5_reg, sec6_reg, sec7_reg, sec8_reg, sec9_reg;
    logic [4:0]  hour5_reg, hour6_reg, hour7_reg, hour8_reg, hour9_reg;

    // Stage 6: year of era and minute.
    logic [35:0] py;
    logic [8:0]  yoe_next, yoe6_reg, yoe7_reg, yoe8_reg, yoe9_reg;
    logic [10:0] hm, min_full;
    logic [5:0]  min6_reg, min7_reg, min8_reg, min9_reg;

    // Stage 7: days of the whole years.
    logic [18:0] pq;
    logic [17:0] y365_next, y365_reg;
    logic [1:0]  yq100_reg;

    // Stage 8: day of year.
    logic [17:0] doy_full;
    logic [8:0]  doy8_reg, doy9_reg;

    // Stage 9: March-based month index.
    logic [10:0] nn;
    logic [22:0] pm;
    logic [3:0]  mp_reg;

    // Stage 10: civil fields.
    logic [8:0]  dfull;
    logic [3:0]  month_sel;
    civil_t      civil_next, civil_reg;

    always_comb
    begin
        ofs_ext   = {{(33-OFS_W){zone_offset[OFS_W-1]}}, zone_offset};
        t_next    = {1'b0, unix_seconds} + 33'(ofs_ext * 33'(SEC_PER_HOUR))
                  + 33'(SEC_PER_DAY);

        pday      = 53'(t_reg[32:7]) * 53'(RECIP_675_36);
        q_next    = pday[51:36];

        qd        = 33'(q_reg) * 33'(SEC_PER_DAY);
        rem_next  = tlo_reg - qd[16:0];
        era5_next = (q_reg >= ERA5_FIRST_DAY);
        doe_next  = 18'(q_reg) + DOE_BIAS - (era5_next ? DAYS_PER_ERA : 18'd0);

        pa        = 32'(doe3_reg[17:2]) * 32'(RECIP_365_24);
        a_next    = pa[30:24];
        b_next    = 3'(doe3_reg >= DOE_CENT1) + 3'(doe3_reg >= DOE_CENT2)
                  + 3'(doe3_reg >= DOE_CENT3) + 3'(doe3_reg >= DOE_LAST);
        c_next    = (doe3_reg == DOE_LAST);
        p60       = 35'(rem3_reg) * 35'(RECIP_60_23);
        q60_next  = p60[33:23];

        adj_next  = doe4_reg - 18'(a_reg) + 18'(b_reg) - 18'(c_reg);
        s60       = 17'(q60_4_reg) * 17'd60;
        sec_full  = rem4_reg - s60;
        ph        = 23'(q60_4_reg) * 23'(RECIP_60_17);

        py        = 36'(adj_reg) * 36'(RECIP_365_26);
        yoe_next  = py[34:26];
        hm        = 11'(hour5_reg) * 11'd60;
        min_full  = q60_5_reg - hm;

        y365_next = 18'(yoe6_reg) * 18'(DAYS_PER_YEAR);
        pq        = 19'(yoe6_reg) * 19'(RECIP_100_16);

        doy_full  = doe7_reg - y365_reg - 18'(yoe7_reg[8:2]) + 18'(yq100_reg);

        nn        = 11'(doy8_reg) * 11'd5 + 11'd2;
        pm        = 23'(nn) * 23'(RECIP_153_19);

        dfull     = doy9_reg - month_start(mp_reg) + 9'd1;
        month_sel = (mp_reg < 4'd10) ? mp_reg + 4'd3 : mp_reg - 4'd9;
        civil_next.year   = 12'(yoe9_reg) + (era9_reg ? ERA5_YEAR : ERA4_YEAR)
                          + 12'(month_sel <= 4'd2);
        civil_next.month  = month_sel;
        civil_next.day    = dfull[4:0];
        civil_next.hour   = hour9_reg;
        civil_next.minute = min9_reg;
        civil_next.second = sec9_reg;
    end

    always_ff @(posedge clk)
    begin
        t_reg     <= t_next;

        q_reg     <= q_next;
        tlo_reg   <= t_reg[16:0];

        rem3_reg  <= rem_next;
        doe3_reg  <= doe_next;
        era3_reg  <= era5_next;

        a_reg     <= a_next;
        b_reg     <= b_next;
        c_reg     <= c_next;
        q60_4_reg <= q60_next;
        rem4_reg  <= rem3_reg;
        doe4_reg  <= doe3_reg;
        era4_reg  <= era3_reg;

        adj_reg   <= adj_next;
        sec5_reg  <= sec_full[5:0];
        hour5_reg <= ph[21:17];
        q60_5_reg <= q60_4_reg;
        doe5_reg  <= doe4_reg;
        era5_reg  <= era4_reg;

        yoe6_reg  <= yoe_next;
        min6_reg  <= min_full[5:0];
        doe6_reg  <= doe5_reg;
        era6_reg  <= era5_reg;
        sec6_reg  <= sec5_reg;
        hour6_reg <= hour5_reg;

        y365_reg  <= y365_next;
        yq100_reg <= pq[17:16];
        yoe7_reg  <= yoe6_reg;
        doe7_reg  <= doe6_reg;
        era7_reg  <= era6_reg;
        sec7_reg  <= sec6_reg;
        hour7_reg <= hour6_reg;
        min7_reg  <= min6_reg;

        doy8_reg  <= doy_full[8:0];
        yoe8_reg  <= yoe7_reg;
        era8_reg  <= era7_reg;
        sec8_reg  <= sec7_reg;
        hour8_reg <= hour7_reg;
        min8_reg  <= min7_reg;

        mp_reg    <= pm[22:19];
        doy9_reg  <= doy8_reg;
        yoe9_reg  <= yoe8_reg;
        era9_reg  <= era8_reg;
        sec9_reg  <= sec8_reg;
        hour9_reg <= hour8_reg;
        min9_reg  <= min8_reg;

        civil_reg <= civil_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[PIPE_DEPTH-2:0], in_valid};
        end
    end

    assign out_valid = valid_reg[PIPE_DEPTH-1];
    assign civil_out = civil_reg;

endmodule

// ===== hw/rtl/unix_civil_time_converter.sv =====
`timescale 1ns / 1ps

// Converts between a 32-bit Unix second count and a proleptic Gregorian date
// and time of day in a local zone that is a whole number of hours from UTC.
// Pulse start with the command and its fields; busy is always low, so a new
// transfer can be started in every clock cycle. Each transfer returns exactly
// one result, shown on the result ports for a single cycle and marked by done,
// in the order of the commands. The receiver cannot stall the block, so it
// must capture the result in the cycle that done is high. The pipeline depth
// is set by the Unix to civil path, a chain of reciprocal multiplies that
// splits the count into days, eras, years, months and time of day; the civil
// to Unix path is padded to the same depth. Command 0 returns the Unix seconds
// (modulo 2^32) for the given local date and time, with the civil result
// fields at zero. Command 1 returns the local date and time for the given
// Unix seconds, with the Unix result at zero. The zone offset register resets
// to zero and is written through cfg_wr_en and cfg_wr_data; write it only
// while no transfer is in flight.

module unix_civil_time_converter import uctc_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              cfg_wr_en,
    input  logic [OFS_W-1:0]  cfg_wr_data,
    input  logic              command,
    input  logic [31:0]       unix_seconds,
    input  logic [11:0]       year,
    input  logic [3:0]        month,
    input  logic [4:0]        day,
    input  logic [4:0]        hour,
    input  logic [5:0]        minute,
    input  logic [5:0]        second,
    output logic              done,
    output logic [31:0]       unix_seconds_out,
    output logic [11:0]       year_out,
    output logic [3:0]        month_out,
    output logic [4:0]        day_out,
    output logic [4:0]        hour_out,
    output logic [5:0]        minute_out,
    output logic [5:0]        second_out
);

    logic [OFS_W-1:0] zone_offset_reg;
    logic             accept;
    civil_t           civil_in;
    civil_t           civil_res;
    logic             unix_valid;
    logic             civil_valid;
    logic [31:0]      unix_res;

    // The pipeline never holds off a transfer.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_offset_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            zone_offset_reg <= cfg_wr_data;
        end
    end

    always_comb
    begin
        civil_in.year   = year;
        civil_in.month  = month;
        civil_in.day    = day;
        civil_in.hour   = hour;
        civil_in.minute = minute;
        civil_in.second = second;
    end

    // Each direction has its own pipeline; only the one the command selects
    // carries a valid bit, so at most one of them presents a result per cycle.
    uctc_to_unix u_to_unix (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (accept && !command),
        .zone_offset  (zone_offset_reg),
        .civil_in     (civil_in),
        .out_valid    (unix_valid),
        .unix_seconds (unix_res)
    );

    uctc_to_civil u_to_civil (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (accept && command),
        .zone_offset  (zone_offset_reg),
        .unix_seconds (unix_seconds),
        .out_valid    (civil_valid),
        .civil_out    (civil_res)
    );

    // Fields that the command does not produce read as zero.
    always_comb
    begin
        done             = unix_valid || civil_valid;
        unix_seconds_out = unix_valid  ? unix_res         : '0;
        year_out         = civil_valid ? civil_res.year   : '0;
        month_out        = civil_valid ? civil_res.month  : '0;
        day_out          = civil_valid ? civil_res.day    : '0;
        hour_out         = civil_valid ? civil_res.hour   : '0;
        minute_out       = civil_valid ? civil_res.minute : '0;
        second_out       = civil_valid ? civil_res.second : '0;
    end

`ifndef ASSERT_OFF
    // The two direction pipelines must never finish in the same cycle.
    a_one_path: assert property (@(posedge clk) disable iff (!rst_n)
        !(unix_valid && civil_valid))
        else $error("both conversion paths produced a result in one cycle");

    // Every accepted transfer returns its result after the fixed latency.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##PIPE_DEPTH done)
        else $error("result missing after an accepted transfer");

    // A result in the civil direction comes from a command 1 transfer.
    a_direction: assert property (@(posedge clk) disable iff (!rst_n)
        civil_valid |-> $past(accept && command, PIPE_DEPTH))
        else $error("civil result without a matching command");
`endif

endmodule
